// File: rtl/core/sql_token_fingerprint_hash_assert.svh
// Assertion macros shared by the fingerprint hash RTL.
`ifndef SQL_TOKEN_FINGERPRINT_HASH_ASSERT_SVH
`define SQL_TOKEN_FINGERPRINT_HASH_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SQLFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SQLFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sqlfp_pkg.sv
// Types, constants and helper functions for the SQL fingerprint hash.
package sqlfp_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

    // Token type codes the classifier cares about
    localparam logic [4:0] TYPE_IDENT   = 5'd0;
    localparam logic [4:0] TYPE_KEYWORD = 5'd1;
    localparam logic [4:0] TYPE_INT     = 5'd2;
    localparam logic [4:0] TYPE_STR     = 5'd3;
    localparam logic [4:0] TYPE_PARAM   = 5'd4;
    localparam logic [4:0] TYPE_SEMI    = 5'd17;
    localparam logic [4:0] TYPE_ERROR   = 5'd18;

    localparam logic [15:0] LEAD_WORD_LEN = 16'd6;
    localparam logic [2:0]  LEAD_WORD_END = 3'd6;
    localparam logic [2:0]  ALL_WORDS     = 3'b111;

    // select, insert, update; bit k of the match mask tracks word k
    localparam logic [7:0] LEAD_WORDS [3][6] = '{
        '{8'h73, 8'h65, 8'h6C, 8'h65, 8'h63, 8'h74},
        '{8'h69, 8'h6E, 8'h73, 8'h65, 8'h72, 8'h74},
        '{8'h75, 8'h70, 8'h64, 8'h61, 8'h74, 8'h65}
    };

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    // What the back end does with one request
    typedef enum logic [3:0] {
        K_CLEAR = 4'd0,
        K_END   = 4'd1,
        K_BYTE  = 4'd2,
        K_FIRST = 4'd3,
        K_BAD   = 4'd4,
        K_SKIP  = 4'd5,
        K_WORD  = 4'd6,
        K_LIT   = 4'd7,
        K_PARAM = 4'd8,
        K_TAG   = 4'd9
    } kind_t;

    // Where token text goes
    typedef enum logic [1:0] {
        TGT_NONE  = 2'd0,
        TGT_SHAPE = 2'd1,
        TGT_ARG   = 2'd2,
        TGT_FIRST = 2'd3
    } target_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  tag;
        logic [1:0]  arg_tag;
        logic        seen;
        logic [15:0] length;
        logic [7:0]  text;
    } entry_t;

    // Shape tag per token type; zero for semicolon and unknown types
    function automatic logic [3:0] shape_tag(input logic [4:0] token_type);
        logic [3:0] tag;
        unique case (token_type)
            5'd0, 5'd1:       tag = 4'd1;
            5'd2, 5'd3, 5'd4: tag = 4'd2;
            5'd5:             tag = 4'd3;
            5'd6:             tag = 4'd4;
            5'd7:             tag = 4'd5;
            5'd8:             tag = 4'd6;
            5'd9:             tag = 4'd7;
            5'd10:            tag = 4'd14;
            5'd11:            tag = 4'd8;
            5'd12:            tag = 4'd9;
            5'd13:            tag = 4'd10;
            5'd14:            tag = 4'd11;
            5'd15:            tag = 4'd12;
            5'd16:            tag = 4'd13;
            default:          tag = 4'd0;
        endcase
        return tag;
    endfunction

    // One FNV-1a byte step; the prime is 2^40 + 0x1B3, so multiply by shift-add
    function automatic logic [63:0] fnv_mix(input logic [63:0] acc, input logic [7:0] b);
        logic [63:0] x;
        x = acc ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    function automatic logic [7:0] fold_ascii(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

endpackage

// File: rtl/core/sqlfp_front.sv
// Front end: classify each incoming item into a back-end request.
module sqlfp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic [4:0]           token_type,
    input  logic [15:0]          token_length,
    input  logic [7:0]           text_byte,
    output logic                 q_push,
    input  logic                 q_ready,
    output sqlfp_pkg::entry_t    q_entry
);

    logic first_pending_reg;
    logic first_pending_next;

    assign in_ready = q_ready;
    assign q_push   = in_valid;

    always_comb
    begin
        q_entry            = '0;
        q_entry.tag        = sqlfp_pkg::shape_tag(token_type);
        q_entry.arg_tag    = token_type[1:0] - 2'd1;
        q_entry.seen       = !first_pending_reg;
        q_entry.length     = token_length;
        q_entry.text       = text_byte;
        first_pending_next = first_pending_reg;
        unique case (sqlfp_pkg::cmd_t'(cmd))
            sqlfp_pkg::CMD_BEGIN:
            begin
                q_entry.kind       = sqlfp_pkg::K_CLEAR;
                first_pending_next = 1'b1;
            end
            sqlfp_pkg::CMD_END:
            begin
                q_entry.kind       = sqlfp_pkg::K_END;
                first_pending_next = 1'b1;
            end
            sqlfp_pkg::CMD_TEXT:
            begin
                q_entry.kind = sqlfp_pkg::K_BYTE;
            end
            default:
            begin
                first_pending_next = 1'b0;
                if (token_type >= sqlfp_pkg::TYPE_ERROR)
                    q_entry.kind = sqlfp_pkg::K_BAD;
                else if (first_pending_reg)
                    q_entry.kind = (token_type == sqlfp_pkg::TYPE_IDENT) ?
                                   sqlfp_pkg::K_FIRST : sqlfp_pkg::K_BAD;
                else if (token_type == sqlfp_pkg::TYPE_SEMI)
                    q_entry.kind = sqlfp_pkg::K_SKIP;
                else if (token_type == sqlfp_pkg::TYPE_IDENT ||
                         token_type == sqlfp_pkg::TYPE_KEYWORD)
                    q_entry.kind = sqlfp_pkg::K_WORD;
                else if (token_type == sqlfp_pkg::TYPE_INT ||
                         token_type == sqlfp_pkg::TYPE_STR)
                    q_entry.kind = sqlfp_pkg::K_LIT;
                else if (token_type == sqlfp_pkg::TYPE_PARAM)
                    q_entry.kind = sqlfp_pkg::K_PARAM;
                else
                    q_entry.kind = sqlfp_pkg::K_TAG;
            end
        endcase
    end

    // Track whether the statement still waits for its first header
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_pending_reg <= 1'b1;
        else if (in_valid && q_ready)
            first_pending_reg <= first_pending_next;
    end

endmodule

// File: rtl/core/sqlfp_queue.sv
// Short request queue between the front and back ends.
module sqlfp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 push_ready,
    input  sqlfp_pkg::entry_t    push_entry,
    output logic                 head_valid,
    input  logic                 pop,
    output sqlfp_pkg::entry_t    head
);

    sqlfp_pkg::entry_t              entries_reg [sqlfp_pkg::QUEUE_DEPTH];
    logic [sqlfp_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [sqlfp_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [sqlfp_pkg::QPTR_W:0]     count_reg;
    logic                           do_push;
    logic                           do_pop;

    function automatic logic [sqlfp_pkg::QPTR_W-1:0] advance(
        input logic [sqlfp_pkg::QPTR_W-1:0] ptr);
        return (ptr == sqlfp_pkg::QPTR_W'(sqlfp_pkg::QUEUE_DEPTH - 1)) ?
               '0 : ptr + 1'b1;
    endfunction

    assign push_ready = (count_reg != (sqlfp_pkg::QPTR_W + 1)'(sqlfp_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= advance(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= advance(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: rtl/core/sqlfp_back.sv
// Back end: run the two FNV-1a hashes, tallies and first-word check.
module sqlfp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  sqlfp_pkg::entry_t             head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [63:0]                   pattern_hash,
    output logic [63:0]                   argument_hash,
    output logic [15:0]                   literal_total,
    output logic [15:0]                   placeholder_total,
    output logic                          fingerprint_valid
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LEN_LO = 3'b010,
        S_LEN_HI = 3'b100
    } state_t;

    state_t                               state_reg, state_next;
    logic [63:0]                          shape_reg, shape_next;
    logic [63:0]                          arg_reg, arg_next;
    logic [sqlfp_pkg::COUNT_BITS-1:0]     lit_reg, lit_next;
    logic [sqlfp_pkg::COUNT_BITS-1:0]     ph_reg, ph_next;
    logic                                 ok_reg, ok_next;
    sqlfp_pkg::target_t                   target_reg, target_next;
    logic [2:0]                           pos_reg, pos_next;
    logic [2:0]                           match_reg, match_next;
    logic [15:0]                          len_reg, len_next;
    logic                                 len_arg_reg, len_arg_next;
    logic                                 out_valid_reg, out_valid_next;

    logic [63:0]                          pattern_reg;
    logic [63:0]                          arg_out_reg;
    logic [15:0]                          lit_out_reg;
    logic [15:0]                          ph_out_reg;
    logic                                 valid_out_reg;

    logic                                 take;
    logic                                 judge_fail;
    logic                                 end_ok;
    logic                                 out_load;
    logic [7:0]                           folded;
    logic                                 shape_en, arg_en;
    logic [7:0]                           shape_byte, arg_byte;
    logic [63:0]                          shape_mix, arg_mix;

    assign take = (state_reg == S_IDLE) && head_valid &&
                  (head.kind != sqlfp_pkg::K_END || !out_valid_reg || out_ready);
    assign pop  = take;

    assign judge_fail = (target_reg == sqlfp_pkg::TGT_FIRST) &&
                        (match_reg == '0 || pos_reg != sqlfp_pkg::LEAD_WORD_END);
    assign end_ok     = ok_reg && !judge_fail && head.seen;
    assign out_load   = take && head.kind == sqlfp_pkg::K_END;
    assign folded     = sqlfp_pkg::fold_ascii(head.text);

    assign shape_mix = sqlfp_pkg::fnv_mix(shape_reg, shape_byte);
    assign arg_mix   = sqlfp_pkg::fnv_mix(arg_reg, arg_byte);

    // Pick at most one byte per hash per cycle
    always_comb
    begin
        shape_en   = 1'b0;
        shape_byte = '0;
        arg_en     = 1'b0;
        arg_byte   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (head.kind) inside
                        sqlfp_pkg::K_FIRST, sqlfp_pkg::K_WORD, sqlfp_pkg::K_LIT,
                        sqlfp_pkg::K_PARAM, sqlfp_pkg::K_TAG:
                        begin
                            shape_en   = 1'b1;
                            shape_byte = {4'd0, head.tag};
                        end
                        sqlfp_pkg::K_BYTE:
                        begin
                            if (target_reg == sqlfp_pkg::TGT_SHAPE ||
                                target_reg == sqlfp_pkg::TGT_FIRST)
                            begin
                                shape_en   = 1'b1;
                                shape_byte = folded;
                            end
                            else if (target_reg == sqlfp_pkg::TGT_ARG)
                            begin
                                arg_en   = 1'b1;
                                arg_byte = head.text;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (head.kind == sqlfp_pkg::K_LIT)
                    begin
                        arg_en   = 1'b1;
                        arg_byte = {6'd0, head.arg_tag};
                    end
                end
            end
            S_LEN_LO:
            begin
                shape_en   = !len_arg_reg;
                arg_en     = len_arg_reg;
                shape_byte = len_reg[7:0];
                arg_byte   = len_reg[7:0];
            end
            S_LEN_HI:
            begin
                shape_en   = !len_arg_reg;
                arg_en     = len_arg_reg;
                shape_byte = len_reg[15:8];
                arg_byte   = len_reg[15:8];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        shape_next     = shape_reg;
        arg_next       = arg_reg;
        lit_next       = lit_reg;
        ph_next        = ph_reg;
        ok_next        = ok_reg;
        target_next    = target_reg;
        pos_next       = pos_reg;
        match_next     = match_reg;
        len_next       = len_reg;
        len_arg_next   = len_arg_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (head.kind) inside
                        sqlfp_pkg::K_CLEAR, sqlfp_pkg::K_END:
                        begin
                            // Start the next statement from the basis
                            shape_next  = sqlfp_pkg::FNV_BASIS;
                            arg_next    = sqlfp_pkg::FNV_BASIS;
                            lit_next    = '0;
                            ph_next     = '0;
                            ok_next     = 1'b1;
                            target_next = sqlfp_pkg::TGT_NONE;
                            pos_next    = '0;
                            match_next  = sqlfp_pkg::ALL_WORDS;
                            if (head.kind == sqlfp_pkg::K_END)
                                out_valid_next = 1'b1;
                        end
                        sqlfp_pkg::K_BYTE:
                        begin
                            if (target_reg == sqlfp_pkg::TGT_FIRST)
                            begin
                                if (pos_reg < sqlfp_pkg::LEAD_WORD_END)
                                begin
                                    for (int k = 0; k < 3; k++)
                                        if (sqlfp_pkg::LEAD_WORDS[k][pos_reg] != folded)
                                            match_next[k] = 1'b0;
                                    pos_next = pos_reg + 3'd1;
                                end
                                else
                                    match_next = '0;
                            end
                        end
                        default:
                        begin
                            // Every header closes the first word and any open text
                            if (judge_fail)
                                ok_next = 1'b0;
                            target_next = sqlfp_pkg::TGT_NONE;
                            len_next    = head.length;
                            case (head.kind)
                                sqlfp_pkg::K_BAD:
                                    ok_next = 1'b0;
                                sqlfp_pkg::K_FIRST:
                                begin
                                    target_next  = sqlfp_pkg::TGT_FIRST;
                                    pos_next     = '0;
                                    match_next   = (head.length == sqlfp_pkg::LEAD_WORD_LEN) ?
                                                   sqlfp_pkg::ALL_WORDS : 3'b000;
                                    len_arg_next = 1'b0;
                                    state_next   = S_LEN_LO;
                                end
                                sqlfp_pkg::K_WORD:
                                begin
                                    target_next  = sqlfp_pkg::TGT_SHAPE;
                                    len_arg_next = 1'b0;
                                    state_next   = S_LEN_LO;
                                end
                                sqlfp_pkg::K_LIT:
                                begin
                                    target_next  = sqlfp_pkg::TGT_ARG;
                                    len_arg_next = 1'b1;
                                    state_next   = S_LEN_LO;
                                    if (lit_reg != '1)
                                        lit_next = lit_reg + 1'b1;
                                end
                                sqlfp_pkg::K_PARAM:
                                begin
                                    if (ph_reg != '1)
                                        ph_next = ph_reg + 1'b1;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    endcase
                end
            end
            S_LEN_LO:
                state_next = S_LEN_HI;
            S_LEN_HI:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase

        if (shape_en)
            shape_next = shape_mix;
        if (arg_en)
            arg_next = arg_mix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            shape_reg     <= sqlfp_pkg::FNV_BASIS;
            arg_reg       <= sqlfp_pkg::FNV_BASIS;
            lit_reg       <= '0;
            ph_reg        <= '0;
            ok_reg        <= 1'b1;
            target_reg    <= sqlfp_pkg::TGT_NONE;
            pos_reg       <= '0;
            match_reg     <= sqlfp_pkg::ALL_WORDS;
            len_arg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shape_reg     <= shape_next;
            arg_reg       <= arg_next;
            lit_reg       <= lit_next;
            ph_reg        <= ph_next;
            ok_reg        <= ok_next;
            target_reg    <= target_next;
            pos_reg       <= pos_next;
            match_reg     <= match_next;
            len_arg_reg   <= len_arg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result and length payload registers
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (out_load)
        begin
            pattern_reg   <= end_ok ? shape_reg : '0;
            arg_out_reg   <= end_ok ? arg_reg : '0;
            lit_out_reg   <= end_ok ? 16'(lit_reg) : '0;
            ph_out_reg    <= end_ok ? 16'(ph_reg) : '0;
            valid_out_reg <= end_ok;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pattern_hash      = pattern_reg;
    assign argument_hash     = arg_out_reg;
    assign literal_total     = lit_out_reg;
    assign placeholder_total = ph_out_reg;
    assign fingerprint_valid = valid_out_reg;

endmodule

// File: rtl/core/sql_token_fingerprint_hash.sv
// Top level of the SQL statement fingerprint hash.
//
// Fingerprints a lexed SQL statement that arrives as a stream of requests:
// begin statement, token header, token text byte and end statement (the
// command travels in s_axis_tuser). Two FNV-1a 64-bit hashes run side by
// side: the pattern hash takes one tag per token but semicolons, plus the
// case-folded text and 16-bit length of identifiers and keywords, the
// argument hash takes the type tag, length and raw text of int and string
// literals. Literals and question-mark parameters are counted with
// saturation. The statement must open with the identifier select, insert or
// update in any letter case, and must carry no error token; otherwise the
// result reports fingerprint_valid low with all other fields zero. Each end
// statement yields exactly one result on the m_axis side; begin statement is
// optional and drops any statement in progress. The front end classifies one
// request per cycle into a four-entry queue, so up to four requests keep
// flowing in while the back end works or while a result waits to be taken; a
// full queue holds s_axis_tready low. The back end retires text bytes,
// begin/end, parameters, semicolons, bad headers and plain tags from S_IDLE;
// identifier, keyword, first-word and literal headers then pass through
// S_LEN_LO and S_LEN_HI, one FNV byte step per cycle through each hash's
// shift-add multiply-by-prime stage, and no request is taken meanwhile.

`include "sql_token_fingerprint_hash_assert.svh"

module sql_token_fingerprint_hash (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // token_type[4:0], token_length[20:5],
                                         // text_byte[28:21], zero fill
    input  logic [1:0]   s_axis_tuser,   // cmd[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // pattern_hash[63:0], argument_hash[127:64],
                                         // literal_total[143:128],
                                         // placeholder_total[159:144]
    output logic [0:0]   m_axis_tuser    // fingerprint_valid[0]
);

    logic                q_push;
    logic                q_ready;
    sqlfp_pkg::entry_t   q_entry;
    logic                q_head_valid;
    logic                q_pop;
    sqlfp_pkg::entry_t   q_head;
    logic [63:0]         pattern_hash;
    logic [63:0]         argument_hash;
    logic [15:0]         literal_total;
    logic [15:0]         placeholder_total;
    logic                fingerprint_valid;
    logic                result_invalid;
    logic                payload_zero;
    logic                pop_len_header;
    logic                pop_end;

    // Classify incoming requests
    sqlfp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .cmd          (s_axis_tuser),
        .token_type   (s_axis_tdata[4:0]),
        .token_length (s_axis_tdata[20:5]),
        .text_byte    (s_axis_tdata[28:21]),
        .q_push       (q_push),
        .q_ready      (q_ready),
        .q_entry      (q_entry)
    );

    // Decouple classification from hashing
    sqlfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_ready),
        .push_entry (q_entry),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .head       (q_head)
    );

    // Hash, count and hold the result until taken
    sqlfp_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_valid        (q_head_valid),
        .head              (q_head),
        .pop               (q_pop),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .pattern_hash      (pattern_hash),
        .argument_hash     (argument_hash),
        .literal_total     (literal_total),
        .placeholder_total (placeholder_total),
        .fingerprint_valid (fingerprint_valid)
    );

    assign m_axis_tdata = {placeholder_total, literal_total, argument_hash, pattern_hash};
    assign m_axis_tuser = fingerprint_valid;

    assign result_invalid = m_axis_tvalid && !m_axis_tuser[0];
    assign payload_zero   = (m_axis_tdata == '0);
    assign pop_len_header = q_pop && (q_head.kind == sqlfp_pkg::K_FIRST ||
                                      q_head.kind == sqlfp_pkg::K_WORD ||
                                      q_head.kind == sqlfp_pkg::K_LIT);
    assign pop_end        = q_pop && q_head.kind == sqlfp_pkg::K_END;

    // An invalid fingerprint carries all-zero fields
    `SQLFP_ASSERT_NOW(a_invalid_zero, result_invalid, payload_zero, "nonzero payload")

    // Length-prefixed headers hold the back end in its length states
    `SQLFP_ASSERT_NEXT(a_header_busy, pop_len_header, !q_pop, "pop during length steps")

    // Retiring an end statement always presents a result
    `SQLFP_ASSERT_NEXT(a_end_result, pop_end, m_axis_tvalid, "end gave no result")

endmodule

// File: tb/sv/sql_token_fingerprint_hash_checker.sv
// Scoreboard for the SQL fingerprint hash: predicts each statement result and compares it.
`timescale 1ns / 1ps

module sql_token_fingerprint_hash_checker
    import sqlfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // token_type[4:0], token_length[20:5],
                                         // text_byte[28:21], zero fill
    input  logic [1:0]   s_axis_tuser,   // cmd[1:0]
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [159:0] m_axis_tdata,   // pattern_hash[63:0], argument_hash[127:64],
                                         // literal_total[143:128],
                                         // placeholder_total[159:144]
    input  logic [0:0]   m_axis_tuser,   // fingerprint_valid[0]
    output int unsigned  fail_count,
    output int unsigned  pending
);

    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

    // Shape tag by token type, type 17 (semicolon) down to type 0
    localparam logic [17:0][3:0] TAG_BY_TYPE = {
        4'd0, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd14, 4'd7,
        4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1
    };

    // Bit k of the live mask follows word k
    localparam logic [2:0][47:0] CANDIDATE_WORDS = {"update", "insert", "select"};

    typedef struct packed {
        logic [63:0] pattern_hash;
        logic [63:0] argument_hash;
        logic [15:0] literal_total;
        logic [15:0] placeholder_total;
        logic        fingerprint_valid;
    } fingerprint_t;

    logic [63:0]           shape_hash;
    logic [63:0]           value_hash;
    logic [COUNT_BITS-1:0] lit_tally;
    logic [COUNT_BITS-1:0] ph_tally;
    logic                  statement_ok;
    logic                  need_lead;
    target_t               text_dest;
    logic [2:0]            lead_pos;
    logic [2:0]            lead_live;
    fingerprint_t          expected_q[$];

    function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
        return (acc ^ {56'd0, b}) * FNV_PRIME;
    endfunction

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    task automatic clear_statement();
        shape_hash   = FNV_BASIS;
        value_hash   = FNV_BASIS;
        lit_tally    = '0;
        ph_tally     = '0;
        statement_ok = 1'b1;
        need_lead    = 1'b1;
        text_dest    = TGT_NONE;
        lead_pos     = '0;
        lead_live    = ALL_WORDS;
    endtask

    // Close the first word: it must be exactly one of the candidates
    task automatic judge_lead_word();
        if (text_dest == TGT_FIRST)
        begin
            if (lead_live == 3'b000 || lead_pos != LEAD_WORD_END)
            begin
                statement_ok = 1'b0;
            end
            text_dest = TGT_NONE;
        end
    endtask

    task automatic absorb_header(input logic [4:0] tt, input logic [15:0] len);
        judge_lead_word();
        text_dest = TGT_NONE;
        if (tt >= TYPE_ERROR)
        begin
            statement_ok = 1'b0;
            need_lead    = 1'b0;
        end
        else if (need_lead)
        begin
            need_lead = 1'b0;
            if (tt != TYPE_IDENT)
            begin
                statement_ok = 1'b0;
            end
            else
            begin
                shape_hash = fnv_step(shape_hash, {4'd0, TAG_BY_TYPE[TYPE_IDENT]});
                shape_hash = fnv_step(fnv_step(shape_hash, len[7:0]), len[15:8]);
                text_dest  = TGT_FIRST;
                lead_pos   = '0;
                lead_live  = (len == LEAD_WORD_LEN) ? ALL_WORDS : 3'b000;
            end
        end
        else if (tt != TYPE_SEMI)
        begin
            shape_hash = fnv_step(shape_hash, {4'd0, TAG_BY_TYPE[tt]});
            if (tt <= TYPE_KEYWORD)
            begin
                shape_hash = fnv_step(fnv_step(shape_hash, len[7:0]), len[15:8]);
                text_dest  = TGT_SHAPE;
            end
            else if (tt == TYPE_INT || tt == TYPE_STR)
            begin
                // int hashes as type tag 1, string as 2
                value_hash = fnv_step(value_hash, {3'd0, tt - 5'd1});
                value_hash = fnv_step(fnv_step(value_hash, len[7:0]), len[15:8]);
                if (lit_tally != '1)
                begin
                    lit_tally = lit_tally + 1'b1;
                end
                text_dest = TGT_ARG;
            end
            else if (tt == TYPE_PARAM)
            begin
                if (ph_tally != '1)
                begin
                    ph_tally = ph_tally + 1'b1;
                end
            end
        end
    endtask

    task automatic absorb_text_byte(input logic [7:0] b);
        logic [7:0] folded;
        folded = lower_ascii(b);
        if (text_dest == TGT_SHAPE || text_dest == TGT_FIRST)
        begin
            shape_hash = fnv_step(shape_hash, folded);
        end
        else if (text_dest == TGT_ARG)
        begin
            value_hash = fnv_step(value_hash, b);
        end
        if (text_dest == TGT_FIRST)
        begin
            if (lead_pos < LEAD_WORD_END)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (CANDIDATE_WORDS[k][47 - 8 * int'(lead_pos) -: 8] != folded)
                    begin
                        lead_live[k] = 1'b0;
                    end
                end
                lead_pos = lead_pos + 3'd1;
            end
            else
            begin
                lead_live = 3'b000;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fingerprint_t got;
        fingerprint_t want;
        logic         ok;
        if (!rst_n)
        begin
            clear_statement();
            expected_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // Retire the result first so a statement ending on this edge is not matched
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.pattern_hash      = m_axis_tdata[63:0];
                got.argument_hash     = m_axis_tdata[127:64];
                got.literal_total     = m_axis_tdata[143:128];
                got.placeholder_total = m_axis_tdata[159:144];
                got.fingerprint_valid = m_axis_tuser[0];
                if (expected_q.size() == 0)
                begin
                    $error("result 0x%0h arrived with no statement ended", got);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("pattern_hash", want.pattern_hash, got.pattern_hash);
                    check_field("argument_hash", want.argument_hash, got.argument_hash);
                    check_field("literal_total", 64'(want.literal_total),
                                64'(got.literal_total));
                    check_field("placeholder_total", 64'(want.placeholder_total),
                                64'(got.placeholder_total));
                    check_field("fingerprint_valid", 64'(want.fingerprint_valid),
                                64'(got.fingerprint_valid));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (cmd_t'(s_axis_tuser))
                    CMD_BEGIN:  clear_statement();
                    CMD_HEADER: absorb_header(s_axis_tdata[4:0], s_axis_tdata[20:5]);
                    CMD_TEXT:   absorb_text_byte(s_axis_tdata[28:21]);
                    default:
                    begin
                        judge_lead_word();
                        ok = statement_ok && !need_lead;
                        want.pattern_hash      = ok ? shape_hash : '0;
                        want.argument_hash     = ok ? value_hash : '0;
                        want.literal_total     = ok ? 16'(lit_tally) : '0;
                        want.placeholder_total = ok ? 16'(ph_tally) : '0;
                        want.fingerprint_valid = ok;
                        expected_q.insert(expected_q.size(), want);
                        clear_statement();
                    end
                endcase
            end
            pending = unsigned'(expected_q.size());
        end
    end

endmodule

// File: tb/sv/sql_token_fingerprint_hash_tb.sv
// Testbench top for the SQL fingerprint hash: drives statement streams and reports the verdict.
`timescale 1ns / 1ps

// Stimulus plan, in order:
//   - a short directed run: a clean statement with mixed-case lead word, keyword,
//     int with full 16-bit length and a 0x00 byte, string with a 0xFF byte, parameter,
//     semicolon with stray text, then the empty statement, a non-ident first token,
//     an unknown type as first token and a leading semicolon; then wait for every
//     result;
//   - about 800 random requests, mostly well-formed statements with random content
//     and a smaller share of noise and broken statements, with idling off for a
//     stretch in the middle.
// The checker beside the block predicts every result and counts mismatches; this
// module only makes requests, holds the result side busy at random and decides.
module sql_token_fingerprint_hash_tb;
    import sqlfp_pkg::*;

    localparam int         RANDOM_REQUESTS = 800;
    // A full run stays well under this limit even with heavy stalls
    localparam int         CYCLE_LIMIT     = 50_000;
    localparam int         TAIL_CYCLES     = 32;
    localparam logic [4:0] TYPE_LAST       = 5'd31;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata  = '0;   // token_type[4:0], token_length[20:5],
                                        // text_byte[28:21], zero fill
    logic [1:0]   s_axis_tuser  = CMD_BEGIN;  // cmd[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;         // pattern_hash[63:0], argument_hash[127:64],
                                        // literal_total[143:128],
                                        // placeholder_total[159:144]
    logic [0:0]   m_axis_tuser;         // fingerprint_valid[0]

    int unsigned  fail_count;
    int unsigned  pending;
    int unsigned  cycle_count = 0;
    int           requests_sent = 0;
    bit           idle_on = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sql_token_fingerprint_hash u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sql_token_fingerprint_hash_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Stall the result side about a quarter of the time while idling is on
    always @(negedge clk)
    begin
        m_axis_tready <= idle_on ? ($urandom_range(99) >= 24) : 1'b1;
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one request and hold it until taken. Call at a falling edge;
    // returns at the falling edge after the handshake with tvalid still high,
    // so a back-to-back request does not lower and raise it in one step.
    task automatic send_request(input cmd_t cmd, input logic [4:0] tt,
                                input logic [15:0] len, input logic [7:0] b);
        while (idle_on && $urandom_range(99) < 24)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, b, len, tt};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        requests_sent++;
        @(negedge clk);
    endtask

    // Drop tvalid and hold off until every ended statement has its result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // One statement: optional begin, lead word, a handful of tokens, end.
    // A few are broken on purpose: wrong first type, wrong length or byte count,
    // a corrupted letter, stray noise, or a missing end.
    task automatic send_statement();
        logic [47:0] word;
        logic [7:0]  ch;
        logic [4:0]  tt;
        logic [15:0] len;
        int          n_bytes;
        int          n_tokens;
        int          roll;
        case ($urandom_range(2))
            0:       word = "select";
            1:       word = "insert";
            default: word = "update";
        endcase
        if ($urandom_range(3) != 0)
        begin
            send_request(CMD_BEGIN, 5'($urandom), 16'($urandom), 8'($urandom));
        end
        roll    = $urandom_range(19);
        tt      = (roll == 0) ? 5'($urandom_range(int'(TYPE_KEYWORD), int'(TYPE_LAST)))
                              : TYPE_IDENT;
        len     = (roll == 1) ? 16'($urandom_range(0, 8)) : LEAD_WORD_LEN;
        n_bytes = (roll == 2) ? $urandom_range(0, 8) : int'(LEAD_WORD_LEN);
        send_request(CMD_HEADER, tt, len, 8'($urandom));
        for (int k = 0; k < n_bytes; k++)
        begin
            ch = (k < 6) ? word[47 - 8 * k -: 8] : 8'($urandom);
            // Mix the letter case; the block must fold it
            if (ch >= 8'h61 && ch <= 8'h7A && $urandom_range(1) == 1)
            begin
                ch = ch - 8'h20;
            end
            if (roll == 3 && $urandom_range(5) == 0)
            begin
                ch = 8'($urandom);
            end
            send_request(CMD_TEXT, 5'($urandom), 16'($urandom), ch);
        end

        n_tokens = $urandom_range(0, 10);
        for (int t = 0; t < n_tokens; t++)
        begin
            roll = $urandom_range(99);
            if (roll < 20)
                tt = 5'($urandom_range(int'(TYPE_IDENT), int'(TYPE_KEYWORD)));
            else if (roll < 40)
                tt = 5'($urandom_range(int'(TYPE_INT), int'(TYPE_STR)));
            else if (roll < 50)
                tt = TYPE_PARAM;
            else if (roll < 85)
                tt = 5'($urandom_range(int'(TYPE_PARAM) + 1, int'(TYPE_SEMI) - 1));
            else if (roll < 92)
                tt = TYPE_SEMI;
            else if (roll < 95)
                tt = 5'($urandom_range(int'(TYPE_ERROR), int'(TYPE_LAST)));
            else
                tt = 5'($urandom);
            // Mostly short tokens; now and then a full-range length with few bytes
            len     = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
            n_bytes = (len <= 16'd6) ? int'(len) : $urandom_range(0, 4);
            if ($urandom_range(9) == 0)
            begin
                n_bytes = $urandom_range(0, 8);
            end
            send_request(CMD_HEADER, tt, len, 8'($urandom));
            for (int k = 0; k < n_bytes; k++)
            begin
                ch = ($urandom_range(1) == 1) ? 8'($urandom_range(8'h41, 8'h7A))
                                              : 8'($urandom);
                send_request(CMD_TEXT, 5'($urandom), 16'($urandom), ch);
            end
            if ($urandom_range(24) == 0)
            begin
                send_request(cmd_t'($urandom_range(3)), 5'($urandom), 16'($urandom),
                             8'($urandom));
            end
        end
        if ($urandom_range(14) != 0)
        begin
            send_request(CMD_END, 5'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int start;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Clean statement exercising each text target and the ignore paths
        send_request(CMD_BEGIN, TYPE_LAST, 16'hFFFF, 8'hFF);
        send_request(CMD_HEADER, TYPE_IDENT, LEAD_WORD_LEN, 8'h00);
        send_request(CMD_TEXT, TYPE_IDENT, 16'h0000, "S");
        send_request(CMD_TEXT, TYPE_IDENT, 16'h0000, "e");
        send_request(CMD_TEXT, TYPE_IDENT, 16'h0000, "L");
        send_request(CMD_TEXT, TYPE_IDENT, 16'h0000, "E");
        send_request(CMD_TEXT, TYPE_IDENT, 16'h0000, "c");
        send_request(CMD_TEXT, TYPE_IDENT, 16'h0000, "T");
        send_request(CMD_HEADER, TYPE_KEYWORD, 16'h0000, 8'h00);
        send_request(CMD_HEADER, TYPE_INT, 16'hFFFF, 8'h00);
        send_request(CMD_TEXT, TYPE_LAST, 16'hFFFF, 8'h00);
        send_request(CMD_HEADER, TYPE_STR, 16'h0001, 8'h00);
        send_request(CMD_TEXT, TYPE_IDENT, 16'h0000, 8'hFF);
        send_request(CMD_HEADER, TYPE_PARAM, 16'h0000, 8'h00);
        // Semicolon is skipped and its text dropped
        send_request(CMD_HEADER, TYPE_SEMI, 16'h0002, 8'h00);
        send_request(CMD_TEXT, TYPE_IDENT, 16'h0000, "A");
        send_request(CMD_END, TYPE_IDENT, 16'h0000, 8'h00);
        // Empty statement, no begin
        send_request(CMD_END, TYPE_IDENT, 16'h0000, 8'h00);
        // First token not an identifier
        send_request(CMD_HEADER, TYPE_INT, 16'h0001, 8'h00);
        send_request(CMD_END, TYPE_IDENT, 16'h0000, 8'h00);
        // Unknown type as first token
        send_request(CMD_HEADER, TYPE_LAST, 16'h0000, 8'h00);
        send_request(CMD_END, TYPE_IDENT, 16'h0000, 8'h00);
        // Leading semicolon
        send_request(CMD_HEADER, TYPE_SEMI, 16'h0000, 8'h00);
        send_request(CMD_END, TYPE_IDENT, 16'h0000, 8'h00);
        drain_results();

        // Random part; switch idling off for a stretch in the middle
        start = requests_sent;
        while (requests_sent - start < RANDOM_REQUESTS)
        begin
            idle_on = !((requests_sent - start >= 300) && (requests_sent - start < 450));
            if ($urandom_range(9) == 0)
            begin
                send_request(cmd_t'($urandom_range(3)), 5'($urandom), 16'($urandom),
                             8'($urandom));
            end
            else
            begin
                send_statement();
            end
        end
        idle_on = 1'b1;

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
